[rtl/ptc_pkg.sv]
// Package for the pixel tint and contrast block: payload structs, lane codes,
// pipeline depths and arithmetic constants. No dependencies.
package ptc_pkg;

    // lane count, channel width and operand widths
    localparam int NUM_LANES   = 3;
    localparam int CH_W        = 8;
    localparam int PCT_W       = 7;
    localparam int COEF_W      = 16;            // N and D both fit in 16 bits
    localparam int PROD_W      = COEF_W + CH_W; // |N*(c-128)|
    localparam int GPROD_W     = CH_W + PCT_W;  // c*p

    // config register map
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT = 2'd1;

    // adjust modes
    localparam logic [2:0] MODE_BLUE_GAIN  = 3'd0;
    localparam logic [2:0] MODE_GREEN_GAIN = 3'd1;
    localparam logic [2:0] MODE_RED_GAIN   = 3'd2;
    localparam logic [2:0] MODE_CONT_UP    = 3'd3;
    localparam logic [2:0] MODE_CONT_DOWN  = 3'd4;

    // arithmetic constants
    localparam logic [PCT_W-1:0]  PCT_MAX       = 7'd100;
    localparam logic [CH_W-1:0]   MID_GREY      = 8'd128;
    localparam logic [8:0]        CONTRAST_K    = 9'd259;
    localparam logic [7:0]        CONTRAST_S    = 8'd255;
    localparam logic [COEF_W-1:0] CONTRAST_BASE = 16'd25900;
    // floor(v/100) == (v*41944) >> 22 for every v below 25600
    localparam logic [15:0]       RECIP_100     = 16'd41944;
    localparam int                RECIP_SHIFT   = 22;

    // quotient bits resolved by the divider stages, one per stage
    localparam int DIV_BITS    = 8;
    // lane stages: operand stage, prep stage, divider stages
    localparam int LANE_STAGES = 2 + DIV_BITS;
    // accept edge to the edge that takes the result
    localparam int ITEM_LAT    = LANE_STAGES + 2;

    // what a lane does with its channel
    typedef enum logic [1:0] {
        OP_PASS,
        OP_GAIN,
        OP_CONTRAST
    } t_lane_op;

    typedef struct packed {
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] red_in;
    } t_pixel_in;

    typedef struct packed {
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] red_out;
    } t_pixel_out;

    // per-item factors shared by all lanes
    typedef struct packed {
        logic [COEF_W-1:0] n;
        logic [COEF_W-1:0] d;
        logic [PCT_W-1:0]  p;
    } t_coef;

endpackage

[rtl/pixel_tint_and_contrast.sv]
// Top level of the pixel tint and contrast block: entry stage, three channel
// lanes and the output merge. Depends on ptc_pkg, ptc_setup, ptc_lane.
//
// One pixel enters per clock: busy stays low, so an item is taken at every
// edge with start high. Its adjusted pixel is on o_result with o_done high for
// exactly one cycle once it has passed the entry, lane and output registers;
// results leave in the order items came in and the receiver must take each
// one as it passes. Each lane holds an operand stage, a prep stage and the
// contrast divide, one quotient bit per stage over eight stages. Config writes
// take effect at once and belong between bursts, with the pipe empty.
module pixel_tint_and_contrast import ptc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_start,
    input  t_pixel_in             i_pixel,
    output logic                  o_busy,
    output logic                  o_done,
    output t_pixel_out            o_result
);

    logic                 load;
    logic [CH_W-1:0]      stage_chan [NUM_LANES];
    t_lane_op             stage_op   [NUM_LANES];
    t_coef                stage_coef;
    logic [CH_W-1:0]      lane_out   [NUM_LANES];
    logic [LANE_STAGES:0] r_vld;
    logic                 r_done;
    t_pixel_out           r_result;

    assign o_busy = 1'b0;
    assign load   = i_start && !o_busy;

    ptc_setup u_setup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_load     (load),
        .i_pixel    (i_pixel),
        .o_chan     (stage_chan),
        .o_op       (stage_op),
        .o_coef     (stage_coef)
    );

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        ptc_lane u_lane (
            .i_clk  (i_clk),
            .i_chan (stage_chan[i]),
            .i_op   (stage_op[i]),
            .i_coef (stage_coef),
            .o_chan (lane_out[i])
        );
    end

    // item tracking alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[LANE_STAGES-1:0], load};
            r_done <= r_vld[LANE_STAGES];
        end
    end

    // merge lanes into the output register
    always_ff @(posedge i_clk) begin
        r_result.blue_out  <= lane_out[0];
        r_result.green_out <= lane_out[1];
        r_result.red_out   <= lane_out[2];
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[rtl/ptc_setup.sv]
// Config registers and the entry stage: latches the pixel, picks each lane's
// operation and works out the contrast factors. Depends on ptc_pkg.
module ptc_setup import ptc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_load,
    input  t_pixel_in             i_pixel,
    output logic [CH_W-1:0]       o_chan [NUM_LANES],
    output t_lane_op              o_op   [NUM_LANES],
    output t_coef                 o_coef
);

    logic [2:0]       r_mode;
    logic [PCT_W-1:0] r_pct;

    logic [PCT_W-1:0]  p_sat;
    logic [16:0]       n_full;
    logic [16:0]       s_full;
    t_coef             n_coef;
    t_lane_op          n_op [NUM_LANES];

    logic [CH_W-1:0]   r_chan [NUM_LANES];
    t_lane_op          r_op   [NUM_LANES];
    t_coef             r_coef;

    // config writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BLUE_GAIN;
            r_pct  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MODE) begin
                r_mode <= i_cfg_data[2:0];
            end else if (i_cfg_idx == CFG_PERCENT) begin
                r_pct <= i_cfg_data;
            end
        end
    end

    // factors: N = 259*(100 +/- p), D = 25900 -/+ 255*p
    always_comb begin
        p_sat  = (r_pct > PCT_MAX) ? PCT_MAX : r_pct;
        s_full = 17'(CONTRAST_S) * 17'(p_sat);
        if (r_mode == MODE_CONT_UP) begin
            n_full   = 17'(CONTRAST_K) * (17'(PCT_MAX) + 17'(p_sat));
            n_coef.d = CONTRAST_BASE - s_full[COEF_W-1:0];
        end else begin
            n_full   = 17'(CONTRAST_K) * (17'(PCT_MAX) - 17'(p_sat));
            n_coef.d = CONTRAST_BASE + s_full[COEF_W-1:0];
        end
        n_coef.n = n_full[COEF_W-1:0];
        n_coef.p = p_sat;
    end

    // lane operations
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            if (r_mode == MODE_CONT_UP || r_mode == MODE_CONT_DOWN) begin
                n_op[i] = OP_CONTRAST;
            end else if (r_mode == 3'(i)) begin
                n_op[i] = OP_GAIN;
            end else begin
                n_op[i] = OP_PASS;
            end
        end
    end

    // entry stage
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chan[0] <= i_pixel.blue_in;
            r_chan[1] <= i_pixel.green_in;
            r_chan[2] <= i_pixel.red_in;
            r_op      <= n_op;
            r_coef    <= n_coef;
        end
    end

    assign o_chan = r_chan;
    assign o_op   = r_op;
    assign o_coef = r_coef;

endmodule

[rtl/ptc_lane.sv]
// One channel lane: pass, gain by adding c*p/100, or contrast by a pipelined restoring
// divide of |N*(c-128)| by D, then saturation. Depends on ptc_pkg.
module ptc_lane import ptc_pkg::*; (
    input  logic            i_clk,
    input  logic [CH_W-1:0] i_chan,
    input  t_lane_op        i_op,
    input  t_coef           i_coef,
    output logic [CH_W-1:0] o_chan
);

    typedef struct packed {
        t_lane_op           op;
        logic [CH_W-1:0]    c;
        logic               neg;
        logic [PROD_W-1:0]  a;
        logic [COEF_W-1:0]  d;
        logic [GPROD_W-1:0] gprod;
    } t_opnd;

    typedef struct packed {
        t_lane_op            op;
        logic [CH_W-1:0]     c;
        logic [CH_W-1:0]     gain;
        logic                neg;
        logic                ovf;
        logic [PROD_W-1:0]   rem;
        logic [COEF_W-1:0]   d;
        logic [DIV_BITS-1:0] q;
    } t_div;

    t_opnd           r_opnd;
    t_opnd           n_opnd;
    logic [CH_W-1:0] mag;
    t_div            r_div [DIV_BITS+1];
    t_div            n_prep;
    logic [30:0]     recip_prod;
    logic [8:0]      gain_sum;

    // operand stage: magnitude of c-128 times N, and c*p
    always_comb begin
        n_opnd.op    = i_op;
        n_opnd.c     = i_chan;
        n_opnd.neg   = (i_chan < MID_GREY);
        mag          = n_opnd.neg ? (MID_GREY - i_chan) : (i_chan - MID_GREY);
        n_opnd.a     = PROD_W'(i_coef.n) * PROD_W'(mag);
        n_opnd.d     = i_coef.d;
        n_opnd.gprod = GPROD_W'(i_chan) * GPROD_W'(i_coef.p);
    end

    always_ff @(posedge i_clk) begin
        r_opnd <= n_opnd;
    end

    // prep stage: gain via reciprocal of 100, quotient range check
    always_comb begin
        recip_prod  = 31'(r_opnd.gprod) * 31'(RECIP_100);
        gain_sum    = 9'(r_opnd.c) + recip_prod[RECIP_SHIFT+8:RECIP_SHIFT];
        n_prep.op   = r_opnd.op;
        n_prep.c    = r_opnd.c;
        n_prep.gain = gain_sum[8] ? 8'hFF : gain_sum[7:0];
        n_prep.neg  = r_opnd.neg;
        n_prep.ovf  = (r_opnd.a >= {r_opnd.d, {DIV_BITS{1'b0}}});
        n_prep.rem  = r_opnd.a;
        n_prep.d    = r_opnd.d;
        n_prep.q    = '0;
    end

    always_ff @(posedge i_clk) begin
        r_div[0] <= n_prep;
    end

    // divider stages, most significant quotient bit first
    for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
        localparam int SH = DIV_BITS - 1 - j;
        logic [PROD_W-1:0] dsh;
        t_div              n_div;

        always_comb begin
            dsh   = PROD_W'(r_div[j].d) << SH;
            n_div = r_div[j];
            if (r_div[j].rem >= dsh) begin
                n_div.rem   = r_div[j].rem - dsh;
                n_div.q[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_div[j+1] <= n_div;
        end
    end

    // final pick and clamp; a negative quotient floors down on a remainder
    logic [8:0] t_up;
    always_comb begin
        t_up = 9'(r_div[DIV_BITS].q) + 9'(r_div[DIV_BITS].rem != '0);
        unique case (r_div[DIV_BITS].op)
            OP_GAIN: o_chan = r_div[DIV_BITS].gain;
            OP_CONTRAST: begin
                if (r_div[DIV_BITS].neg) begin
                    if (r_div[DIV_BITS].ovf || t_up > 9'(MID_GREY)) begin
                        o_chan = '0;
                    end else begin
                        o_chan = MID_GREY - t_up[7:0];
                    end
                end else begin
                    if (r_div[DIV_BITS].ovf || r_div[DIV_BITS].q >= MID_GREY) begin
                        o_chan = 8'hFF;
                    end else begin
                        o_chan = MID_GREY + r_div[DIV_BITS].q;
                    end
                end
            end
            default: o_chan = r_div[DIV_BITS].c;
        endcase
    end

endmodule

[rtl/ptc_checker.sv]
// Port-level checks for pixel_tint_and_contrast and the bind that attaches
// them. Depends on ptc_pkg and the top level's ports.
module ptc_checker import ptc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       o_busy,
    input  logic       o_done
);

    // full rate: the block never pushes back
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

    // every accepted item comes out, with o_done seen at the edge that takes its result
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##ITEM_LAT o_done)
        else $error("result missing");

    // no result without an item accepted at the matching edge
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, ITEM_LAT))
        else $error("result without item");

endmodule

bind pixel_tint_and_contrast ptc_checker u_ptc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done)
);
